// ===== sv/hbd_pkg.sv =====
// Shared types and constants for the tree Huffman byte decoder.
// No dependencies; every other file of the block but hbd_ram refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

    // Default tree store address width (512 entries)
    localparam int TREE_AW_DEF = 9;

    // Field widths
    localparam int IDX_W   = 9;
    localparam int VAL_W   = 16;
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 32;
    localparam int BITC_W  = $clog2(WORD_W);

    // Input stream layout: tree_index, tree_value, data_word, padded to bytes
    localparam int S_TDATA_W = ((IDX_W + VAL_W + WORD_W + 7) / 8) * 8;
    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = IDX_LSB + IDX_W;
    localparam int WORD_LSB  = VAL_LSB + VAL_W;

    // Item kinds carried on tuser
    localparam logic OP_TREE = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Configuration register indexes
    localparam logic CFG_TREE_ROOT     = 1'b0;
    localparam logic CFG_OUTPUT_LENGTH = 1'b1;

    // Bit of a leaf word that marks a leaf reached on a 0 bit
    localparam int LEAF_FLAG_BIT = 8;

    // Decoded byte handed from the walker to the output register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } emit_t;

endpackage

`default_nettype wire

// ===== sv/hbd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module hbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/hbd_walker.sv =====
// Bit-serial tree walker: shifts the data word out MSB first, one tree read per bit.
// Holds the configuration registers, node index and byte count. Uses hbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbd_walker #(
    parameter int TREE_AW = hbd_pkg::TREE_AW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // data word start
    input  wire logic                          start,
    input  wire logic [hbd_pkg::WORD_W-1:0]    word,
    // configuration write
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_index,
    input  wire logic [hbd_pkg::CNT_W-1:0]     cfg_wr_data,
    output logic                               busy,
    // tree store read port
    output logic                               rd_en,
    output logic [TREE_AW-1:0]                 rd_addr,
    input  wire logic [hbd_pkg::VAL_W-1:0]     rd_data,
    // decoded bytes
    output hbd_pkg::emit_t                     emit,
    input  wire logic                          emit_ready
);

    localparam int IDX_WIDE = (TREE_AW > hbd_pkg::IDX_W) ? TREE_AW : hbd_pkg::IDX_W;

    // walker states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    localparam logic [hbd_pkg::BITC_W-1:0] BIT_LAST = hbd_pkg::BITC_W'(hbd_pkg::WORD_W - 1);

    logic [1:0]                     state_reg, state_next;
    logic [hbd_pkg::IDX_W-1:0]      root_reg, root_next;
    logic [hbd_pkg::CNT_W-1:0]      len_reg, len_next;
    logic [hbd_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [TREE_AW-1:0]             node_reg, node_next;
    logic [hbd_pkg::WORD_W-1:0]     shift_reg, shift_next;
    logic [hbd_pkg::BITC_W-1:0]     bitc_reg, bitc_next;

    logic [IDX_WIDE-1:0]            root_wide;
    logic [IDX_WIDE-1:0]            cfg_root_wide;
    logic [TREE_AW-1:0]             root_idx;
    logic [TREE_AW-1:0]             cfg_root_idx;
    logic [TREE_AW-1:0]             node_dec;
    logic signed [hbd_pkg::VAL_W-1:0] w;
    logic signed [hbd_pkg::VAL_W-1:0] half;
    logic                           cur_bit;
    logic                           is_leaf;
    logic [hbd_pkg::CNT_W-1:0]      count_inc;
    logic                           is_last;

    // root index wrapped to the store size
    assign root_wide     = IDX_WIDE'(root_reg);
    assign root_idx      = root_wide[TREE_AW-1:0];
    assign cfg_root_wide = IDX_WIDE'(cfg_wr_data[hbd_pkg::IDX_W-1:0]);
    assign cfg_root_idx  = cfg_root_wide[TREE_AW-1:0];

    // node word decode
    assign cur_bit   = shift_reg[hbd_pkg::WORD_W-1];
    assign node_dec  = node_reg - TREE_AW'(1);
    assign w         = $signed(rd_data);
    // divide by two, truncating toward zero
    assign half      = (w + $signed({{(hbd_pkg::VAL_W-1){1'b0}}, w[hbd_pkg::VAL_W-1]})) >>> 1;
    assign is_leaf   = cur_bit ? !w[hbd_pkg::VAL_W-1]
                               : (!w[hbd_pkg::VAL_W-1] && w[hbd_pkg::LEAF_FLAG_BIT]);
    assign count_inc = count_reg + hbd_pkg::CNT_W'(1);
    assign is_last   = (count_inc == len_reg);

    assign busy    = (state_reg != ST_IDLE);
    assign rd_addr = cur_bit ? node_reg : node_dec;

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        root_next  = root_reg;
        len_next   = len_reg;
        count_next = count_reg;
        node_next  = node_reg;
        shift_next = shift_reg;
        bitc_next  = bitc_reg;
        rd_en      = 1'b0;
        emit.valid     = 1'b0;
        emit.data_byte = rd_data[hbd_pkg::BYTE_W-1:0];
        emit.last      = is_last;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (count_reg != len_reg))
                begin
                    shift_next = word;
                    bitc_next  = '0;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                rd_en      = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // a leaf waits here until the output register has room
                if (!is_leaf || emit_ready)
                begin
                    if (is_leaf)
                    begin
                        emit.valid = 1'b1;
                        count_next = count_inc;
                        node_next  = root_idx;
                    end
                    else if (cur_bit)
                    begin
                        node_next = node_reg + half[TREE_AW-1:0];
                    end
                    else
                    begin
                        node_next = node_dec;
                    end
                    shift_next = shift_reg << 1;
                    bitc_next  = bitc_reg + hbd_pkg::BITC_W'(1);
                    if ((bitc_reg == BIT_LAST) || (is_leaf && is_last))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register write restarts decoding
        if (cfg_wr_en)
        begin
            count_next = '0;
            unique case (cfg_wr_index)
                hbd_pkg::CFG_TREE_ROOT:
                begin
                    root_next = cfg_wr_data[hbd_pkg::IDX_W-1:0];
                    node_next = cfg_root_idx;
                end
                hbd_pkg::CFG_OUTPUT_LENGTH:
                begin
                    len_next  = cfg_wr_data;
                    node_next = root_idx;
                end
                default:
                begin
                    node_next = root_idx;
                end
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            root_reg  <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            node_reg  <= '0;
            bitc_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            root_reg  <= root_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            node_reg  <= node_next;
            bitc_reg  <= bitc_next;
        end
    end

    // data shift register
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

`default_nettype wire

// ===== sv/tree_huffman_byte_decoder_unit.sv =====
// Tree Huffman byte decoder: tree words go to a 2**TREE_AW entry tree store,
// data words are walked one bit at a time (tree read, then evaluate).
// A tree write does not hold the input; a data word holds it until its walk ends, at the end
// of the word or earlier if the run ends mid-word, and longer while the output stalls.
// A decoded byte passes through the tree store read register, then the output register.
// Reset clears control state; tree store contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module tree_huffman_byte_decoder_unit #(
    parameter int TREE_AW = hbd_pkg::TREE_AW_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [8:0] tree_index, [24:9] tree_value, [56:25] data_word, [63:57] zero
    input  wire logic [hbd_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] operation
    input  wire logic                            s_tuser,
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] data_byte
    output logic      [hbd_pkg::BYTE_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [hbd_pkg::CNT_W-1:0]       cfg_data
);

    localparam int TREE_ENTRIES = 1 << TREE_AW;
    localparam int IDX_WIDE = (TREE_AW > hbd_pkg::IDX_W) ? TREE_AW : hbd_pkg::IDX_W;

    logic                          s_accept;
    logic                          tree_wr;
    logic                          data_start;
    logic                          busy;
    logic                          rd_en;
    logic [TREE_AW-1:0]            rd_addr;
    logic [hbd_pkg::VAL_W-1:0]     rd_data;
    logic [IDX_WIDE-1:0]           wr_idx_wide;
    hbd_pkg::emit_t                emit;
    logic                          emit_ready;

    logic                          out_valid_reg, out_valid_next;
    logic [hbd_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                          out_last_reg;

    // input decode
    assign s_tready    = !busy;
    assign s_accept    = s_tvalid && s_tready;
    assign tree_wr     = s_accept && (s_tuser == hbd_pkg::OP_TREE);
    assign data_start  = s_accept && (s_tuser == hbd_pkg::OP_DATA);
    assign wr_idx_wide = IDX_WIDE'(s_tdata[hbd_pkg::IDX_LSB +: hbd_pkg::IDX_W]);
    assign cfg_ready   = 1'b1;

    hbd_ram #(
        .WIDTH (hbd_pkg::VAL_W),
        .DEPTH (TREE_ENTRIES)
    ) u_tree_store (
        .clk     (clk),
        .wr_en   (tree_wr),
        .wr_addr (wr_idx_wide[TREE_AW-1:0]),
        .wr_data (s_tdata[hbd_pkg::VAL_LSB +: hbd_pkg::VAL_W]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hbd_walker #(
        .TREE_AW (TREE_AW)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (data_start),
        .word         (s_tdata[hbd_pkg::WORD_LSB +: hbd_pkg::WORD_W]),
        .cfg_wr_en    (cfg_valid && cfg_ready),
        .cfg_wr_index (cfg_index),
        .cfg_wr_data  (cfg_data),
        .busy         (busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .emit         (emit),
        .emit_ready   (emit_ready)
    );

    // output register
    assign emit_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_byte_reg <= emit.data_byte;
            out_last_reg <= emit.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/hbd_checker.sv =====
// Port-level checks for the tree Huffman byte decoder, bound to the top level.
// Uses hbd_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module hbd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [hbd_pkg::BYTE_W-1:0]    m_tdata,
    input wire logic                          m_tlast
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // a tree write never starts a walk
    a_tree_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == hbd_pkg::OP_TREE) |=> s_tready)
        else $error("input blocked after a tree write");

    // bytes only come out of a walk in progress
    a_out_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result item without a walk");

    // nothing follows the last byte of a run directly
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result item right after the last byte");

endmodule

bind tree_huffman_byte_decoder_unit hbd_checker u_hbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the tree Huffman byte decoder unit.
// Depends on hbd_pkg and tree_huffman_byte_decoder_unit (with hbd_walker and hbd_ram beneath it).
// Tree words are generated so that every walk only ever reads stored entries.
`timescale 1ns / 1ps

module testbench;

    localparam int STORE_DEPTH  = 512;
    localparam int DRAIN_CYCLES = 100;   // one full data word plus margin
    localparam int LONG_HOLD    = 600;   // receiver hold-off for the stall test

    typedef struct packed {
        logic [hbd_pkg::BYTE_W-1:0] data_byte;
        logic                       last;
    } decoded_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [hbd_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = hbd_pkg::OP_TREE;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [hbd_pkg::BYTE_W-1:0]    m_tdata;
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_index = hbd_pkg::CFG_TREE_ROOT;
    logic [hbd_pkg::CNT_W-1:0]     cfg_data = '0;

    // Decoder mirror: tree store, which entries hold a word, walk position
    logic signed [hbd_pkg::VAL_W-1:0] tree_mem [STORE_DEPTH];
    bit                               stored [STORE_DEPTH];
    logic [hbd_pkg::IDX_W-1:0]        walk_node = '0;
    logic [hbd_pkg::CNT_W-1:0]        produced = '0;
    logic [hbd_pkg::IDX_W-1:0]        root_reg = '0;
    logic [hbd_pkg::CNT_W-1:0]        len_reg = '0;
    decoded_byte_t                    pending_bytes [$];

    int errors = 0;
    int items_sent = 0;
    int tree_items = 0;
    int data_items = 0;
    int reg_writes = 0;
    int tree_setups = 0;
    int bytes_checked = 0;
    int lasts_seen = 0;
    int burst_left = 0;

    // Receiver pacing state
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int ready_mode = 0;
    int mode_left = 0;
    int cyc = 0;

    tree_huffman_byte_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Receiver: long hold-off on request, otherwise a pacing mode that changes now and then
    always @(posedge clk)
    begin
        cyc++;
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            else
                mode_left--;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 2) != 0);
                default: m_tready <= ((cyc % 7) < 4);
            endcase
        end
    end

    // Result check against the oldest pending byte
    decoded_byte_t got_ref;
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected item: data_byte %02h last %0b", m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                got_ref = pending_bytes.pop_front();
                if (m_tdata !== got_ref.data_byte)
                begin
                    $error("data_byte: expected %02h, actual %02h", got_ref.data_byte, m_tdata);
                    errors++;
                end
                if (m_tlast !== got_ref.last)
                begin
                    $error("last: expected %0b, actual %0b", got_ref.last, m_tlast);
                    errors++;
                end
                bytes_checked++;
                if (got_ref.last)
                    lasts_seen++;
            end
        end
    end

    // Walks one data word through the mirrored tree and queues the bytes it yields.
    // A 0 bit whose step would read an empty entry is turned into a 1 bit.
    task decode_word(inout logic [hbd_pkg::WORD_W-1:0] word);
        logic signed [hbd_pkg::VAL_W-1:0] w;
        logic [hbd_pkg::IDX_W-1:0]        prev;
        logic                             emit;
        decoded_byte_t                    db;
        int                               b;
        for (b = hbd_pkg::WORD_W - 1; b >= 0 && produced < len_reg; b--)
        begin
            emit = 1'b0;
            prev = walk_node - 9'd1;
            if (!word[b] && !stored[prev])
                word[b] = 1'b1;
            if (word[b])
            begin
                w = tree_mem[walk_node];
                if (w >= 0)
                    emit = 1'b1;
                else
                    walk_node = 9'(int'(walk_node) + int'(w) / 2);
            end
            else
            begin
                walk_node = prev;
                w = tree_mem[walk_node];
                if (w > 0 && w[hbd_pkg::LEAF_FLAG_BIT])
                    emit = 1'b1;
            end
            if (emit)
            begin
                produced++;
                db.data_byte = w[hbd_pkg::BYTE_W-1:0];
                db.last = (produced == len_reg);
                pending_bytes.push_back(db);
                walk_node = root_reg;
            end
        end
    endtask

    // Random node word: leaf for both bit values, leaf for 1 bits only, or a jump
    // whose target (modulo the store size) lies in the tree at lo..lo+span-1
    function automatic logic [hbd_pkg::VAL_W-1:0] make_node(
        logic [hbd_pkg::IDX_W-1:0] idx,
        logic [hbd_pkg::IDX_W-1:0] lo,
        int span);
        logic [hbd_pkg::VAL_W-1:0] v;
        logic [hbd_pkg::IDX_W-1:0] target;
        int kind, m, kmin, k, d, r;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            v = 16'($urandom);
            v[15] = 1'b0;
            v[hbd_pkg::LEAF_FLAG_BIT] = 1'b1;
        end
        else if (kind < 60)
        begin
            v = 16'($urandom);
            v[15] = 1'b0;
            v[hbd_pkg::LEAF_FLAG_BIT] = 1'b0;
        end
        else
        begin
            target = lo + 9'($urandom_range(0, span - 1));
            m = int'(9'(target - idx));
            kmin = (m == 0) ? 0 : 1;
            // mostly the short jump, sometimes many laps around the store
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(kmin, 32) : kmin;
            d = m - STORE_DEPTH * k;
            r = $urandom_range(0, 1);
            if (d == 0)
                r = 1;
            if (d == -16384)
                r = 0;
            v = 16'(2 * d - r);
        end
        return v;
    endfunction

    // Sends one input item; the sender runs in bursts with random gaps
    task send_item(input logic op, input logic [hbd_pkg::IDX_W-1:0] idx,
                   input logic [hbd_pkg::VAL_W-1:0] val,
                   input logic [hbd_pkg::WORD_W-1:0] word);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, word, val, idx};
        do @(posedge clk); while (!s_tready);
        burst_left--;
        items_sent++;
        if (op == hbd_pkg::OP_DATA)
            data_items++;
        else
            tree_items++;
    endtask

    task store_node(input logic [hbd_pkg::IDX_W-1:0] idx,
                    input logic [hbd_pkg::VAL_W-1:0] val);
        tree_mem[idx] = val;
        stored[idx] = 1'b1;
        send_item(hbd_pkg::OP_TREE, idx, val, $urandom);
    endtask

    task send_data(input logic [hbd_pkg::WORD_W-1:0] word_in);
        logic [hbd_pkg::WORD_W-1:0] word;
        word = word_in;
        decode_word(word);
        send_item(hbd_pkg::OP_DATA, 9'($urandom), 16'($urandom), word);
    endtask

    // Stop sending, let every pending byte arrive and the walker finish its word
    task settle;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; either register restarts the walk
    task write_reg(input logic idx, input logic [hbd_pkg::CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == hbd_pkg::CFG_TREE_ROOT)
            root_reg = value[hbd_pkg::IDX_W-1:0];
        else
            len_reg = value;
        walk_node = root_reg;
        produced = '0;
        reg_writes++;
        @(posedge clk);
    endtask

    // One setup: load a tree at lo..lo+span-1, restart, then data words with
    // occasional tree rewrites in between
    task run_phase(input logic [hbd_pkg::IDX_W-1:0] lo, input int span, input int off,
                   input logic [hbd_pkg::CNT_W-1:0] len, input int n_items,
                   input bit long_stall);
        logic [hbd_pkg::CNT_W-1:0]  root_word;
        logic [hbd_pkg::IDX_W-1:0]  idx;
        logic [hbd_pkg::WORD_W-1:0] word;
        int i;
        settle();
        for (i = 0; i < span; i++)
        begin
            idx = lo + 9'(i);
            store_node(idx, make_node(idx, lo, span));
        end
        settle();
        // upper bits of the root write are don't-care
        root_word = $urandom;
        root_word[hbd_pkg::IDX_W-1:0] = lo + 9'(off);
        if ($urandom_range(0, 1))
        begin
            write_reg(hbd_pkg::CFG_TREE_ROOT, root_word);
            write_reg(hbd_pkg::CFG_OUTPUT_LENGTH, len);
        end
        else
        begin
            write_reg(hbd_pkg::CFG_OUTPUT_LENGTH, len);
            write_reg(hbd_pkg::CFG_TREE_ROOT, root_word);
        end
        tree_setups++;
        if (long_stall)
            hold_requests++;
        for (i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 99) < 88)
            begin
                case ($urandom_range(0, 3))
                    1:       word = $urandom | $urandom;
                    2:       word = $urandom & $urandom;
                    default: word = $urandom;
                endcase
                send_data(word);
            end
            else
            begin
                idx = lo + 9'($urandom_range(0, span - 1));
                store_node(idx, make_node(idx, lo, span));
            end
        end
    endtask

    // Zero output length: data words are dropped without touching the tree
    task test_empty_run;
        write_reg(hbd_pkg::CFG_OUTPUT_LENGTH, 32'd0);
        send_data(32'hFFFF_FFFF);
        send_data(32'h0000_0000);
    endtask

    // Hand-built tree: self jump at -32768, stay at -1, wrapping jump to 0,
    // step below index 0 to 511, tree write mid-run, end mid-word, finished run
    task test_hand_tree;
        settle();
        store_node(9'd0, 16'h0141);
        store_node(9'd1, 16'h00FF);
        store_node(9'd2, 16'h8000);
        store_node(9'd3, 16'hFFFD);
        store_node(9'd4, 16'h7FFF);
        store_node(9'd5, 16'hFFFF);
        store_node(9'd6, 16'hEFF4);
        store_node(9'd511, 16'h0000);
        settle();
        write_reg(hbd_pkg::CFG_TREE_ROOT, 32'hFFFF_FE06);
        write_reg(hbd_pkg::CFG_OUTPUT_LENGTH, 32'hFFFF_FFFF);
        tree_setups++;
        send_data(32'h0000_0000);
        send_data(32'hFFFF_FFFF);
        send_data(32'hAAAA_AAAA);
        store_node(9'd1, 16'h01C3);
        send_data(32'h5555_5555);
        send_data(32'h8000_0001);
        send_data(32'h1234_5678);
        settle();
        write_reg(hbd_pkg::CFG_OUTPUT_LENGTH, 32'd3);
        send_data(32'hFFFF_FFFF);
        send_data(32'hFFFF_FFFF);
    endtask

    // Root at the top index and at index 0, trees wrapping around the store
    task test_root_extremes;
        run_phase(9'd505, 7, 6, 32'hFFFF_FFFF, 14, 1'b0);
        run_phase(9'd500, 13, 12, 32'd40, 14, 1'b0);
        run_phase(9'd0, 4, 0, 32'd1, 6, 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering data words
    task test_output_stall;
        run_phase(9'($urandom), 3, 2, 32'hFFFF_FFFF, 14, 1'b1);
    endtask

    task test_random_trees;
        logic [hbd_pkg::CNT_W-1:0] len;
        int span;
        while (items_sent < 370)
        begin
            span = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 64)
                                               : $urandom_range(2, 14);
            case ($urandom_range(0, 9))
                0:       len = 32'd0;
                1:       len = 32'hFFFF_FFFF;
                2:       len = $urandom;
                3, 4, 5: len = $urandom_range(1, 12);
                default: len = $urandom_range(13, 150);
            endcase
            run_phase(9'($urandom), span, $urandom_range(0, span - 1), len,
                      $urandom_range(6, 24), 1'b0);
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_run();
        test_hand_tree();
        test_root_extremes();
        test_output_stall();
        test_random_trees();
        settle();
        $display("Sent %0d items (%0d tree words, %0d data words) over %0d tree setups,",
                 items_sent, tree_items, data_items, tree_setups);
        $display("%0d register writes; checked %0d decoded bytes, %0d of them ending a run.",
                 reg_writes, bytes_checked, lasts_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
